/* rtl/core/itoa_pkg.sv */
// Shared types and constants for the signed integer to decimal text converter.
`timescale 1ns / 1ps
`default_nettype none
package itoa_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned CharW   = 8;
  localparam int unsigned MaxDig  = 10;
  localparam int unsigned CntW    = 4;

  localparam logic [CharW-1:0]  CharZero  = 8'd48;
  localparam logic [CharW-1:0]  CharMinus = 8'd45;
  // ceil(2^35 / 10): exact quotient by ten for any 32-bit unsigned value
  localparam logic [ValueW-1:0] RecipTen  = 32'hCCCC_CCCD;
  localparam int unsigned       RecipSh   = 35;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } itoa_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic emit_sign;
    logic emit_digit;
  } itoa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic neg;
    logic quot_zero;
    logic last_digit;
  } itoa_sts_t;

endpackage
`default_nettype wire

/* rtl/core/itoa_dp.sv */
// Datapath: magnitude register, divide-by-ten step, digit buffer and output beat register.
`timescale 1ns / 1ps
`default_nettype none
module itoa_dp
  import itoa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ValueW-1:0] value_i,
  input  wire itoa_cmd_t         cmd_i,
  output itoa_sts_t              sts_o,
  output logic                   valid_o,
  output logic [CharW-1:0]       character_o,
  output logic                   last_o
);

  logic [ValueW-1:0]   mag_q;
  logic                neg_q;
  logic [CntW-1:0]     cnt_q;
  logic [CntW-1:0]     rd_idx;
  logic [3:0]          digits_q [MaxDig];
  logic [2*ValueW-1:0] prod;
  logic [ValueW-1:0]   quot;
  logic [3:0]          rem;
  logic                valid_q;
  logic                last_q;
  logic [CharW-1:0]    char_q;

  assign prod = {{ValueW{1'b0}}, mag_q} * {{ValueW{1'b0}}, RecipTen};
  assign quot = ValueW'(prod[2*ValueW-1:RecipSh]);
  // remainder is below ten, so only the low nibble of mag - 10*quot is needed
  assign rem  = mag_q[3:0] - ({quot[0], 3'b000} + {quot[2:0], 1'b0});

  assign rd_idx = cnt_q - 4'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit_sign | cmd_i.emit_digit;
      last_q  <= cmd_i.emit_digit & (cnt_q == 4'd1);
      if (cmd_i.load) begin
        cnt_q <= '0;
        neg_q <= value_i[ValueW-1];
      end else if (cmd_i.step) begin
        cnt_q <= cnt_q + 4'd1;
      end else if (cmd_i.emit_digit) begin
        cnt_q <= rd_idx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= value_i[ValueW-1] ? (ValueW'(0) - value_i) : value_i;
    end else if (cmd_i.step) begin
      mag_q <= quot;
      digits_q[cnt_q] <= rem;
    end
    if (cmd_i.emit_sign) begin
      char_q <= CharMinus;
    end else if (cmd_i.emit_digit) begin
      char_q <= CharZero + {4'b0000, digits_q[rd_idx]};
    end
  end

  assign sts_o.neg        = neg_q;
  assign sts_o.quot_zero  = (quot == '0);
  assign sts_o.last_digit = (cnt_q == 4'd1);

  assign valid_o     = valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

/* rtl/core/itoa_ctrl.sv */
// Controller: sequences load, digit extraction, sign beat and digit beats.
`timescale 1ns / 1ps
`default_nettype none
module itoa_ctrl
  import itoa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire itoa_sts_t sts_i,
  output itoa_cmd_t      cmd_o,
  output logic           busy_o
);

  itoa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.step = 1'b1;
        if (sts_i.quot_zero) begin
          state_d = sts_i.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        cmd_o.emit_sign = 1'b1;
        state_d         = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit_digit = 1'b1;
        if (sts_i.last_digit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/signed_int_to_decimal_ascii_top.sv */
// Top level of the signed 32-bit integer to decimal ASCII converter.
//
// Usage: drive value_i and raise start; the value is taken at a rising edge
// where start is high and busy is low. busy then stays high until the last
// character has been issued.
// Output: one character per cycle on character_o, marked by valid_o for a
// single cycle; last_o flags the final character of the text. A negative
// value gives a leading '-' first. There is no back-pressure: the receiver
// must take every beat as it appears.
// Timing: digits are extracted one per cycle (a single
// multiply-by-reciprocal divide-by-ten unit, reused every cycle), then the
// characters are issued one per cycle; busy covers extraction, the sign and
// every digit beat. A new value may be accepted in the cycle the last
// character is shown.
// Reset: asynchronous, active low; returns to idle and drops valid_o.
`timescale 1ns / 1ps
`default_nettype none
module signed_int_to_decimal_ascii_top
  import itoa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic [ValueW-1:0] value_i,
  output logic                   busy,
  output logic                   valid_o,
  output logic [CharW-1:0]       character_o,
  output logic                   last_o
);

  itoa_cmd_t cmd;
  itoa_sts_t sts;

  itoa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  itoa_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .value_i    (value_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .valid_o    (valid_o),
    .character_o(character_o),
    .last_o     (last_o)
  );

`ifndef SYNTH
  // every beat carries a minus sign or a decimal digit
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (character_o == CharMinus) ||
                ((character_o >= CharZero) && (character_o <= CharZero + 8'd9)))
    else $error("character outside sign/digit range");

  // the sign never ends a run
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (character_o == CharMinus)) |-> !last_o)
    else $error("minus sign flagged as last");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> valid_o)
    else $error("last without valid beat");

  // an accepted value always occupies the block for the next cycle
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !valid_o))
    else $error("busy not raised after accept");
`endif

endmodule
`default_nettype wire
